// ===== rtl/tdq_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tdq_pkg
// Shared types and codes for the task deque: request kinds, status codes,
// controller states and the command/status bundles between the two halves.
// ============================================================================
package tdq_pkg;

    localparam int DEPTH_DEF    = 16;
    localparam int ID_WIDTH_DEF = 16;

    localparam int KIND_W   = 3;
    localparam int IDENT_W  = 16;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DELETE     = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP_WAIT,
        S_SCAN,
        S_SHIFT
    } ctrl_state_t;

    typedef enum logic [1:0] {
        OFS_ZERO,
        OFS_LAST,
        OFS_POS1,
        OFS_POS2
    } rd_ofs_t;

    typedef enum logic [1:0] {
        WR_FRONT,
        WR_BACK,
        WR_SHIFT
    } wr_sel_t;

    typedef enum logic [1:0] {
        PTR_HOLD,
        PTR_INC,
        PTR_DEC
    } ptr_op_t;

    typedef enum logic [1:0] {
        POS_HOLD,
        POS_CLEAR,
        POS_INC
    } pos_op_t;

    typedef struct packed {
        logic                load;
        logic                rd_en;
        rd_ofs_t             rd_ofs;
        logic                wr_en;
        wr_sel_t             wr_sel;
        ptr_op_t             front_op;
        ptr_op_t             count_op;
        pos_op_t             pos_op;
        logic                finish;
        logic                got_rd;
        logic [STATUS_W-1:0] status;
    } dp_cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              full;
        logic              empty;
        logic              match;
        logic              pos1_lt;
        logic              pos2_lt;
    } dp_stat_t;

endpackage

// ===== rtl/task_deque_with_remove_by_id_unit.sv =====
`timescale 1ns / 1ps
// ============================================================================
// task_deque_with_remove_by_id_unit
// Bounded double-ended queue of task identifiers with delete by identifier.
// ============================================================================
// Sequence: push, no-op and rejected requests finish in S_EXEC; pops read
// in S_EXEC and finish in S_POP_WAIT; a delete reads in S_EXEC, then
// scans and shifts as many entries as the count held, one per cycle
// through the single registered read port of the entry store.
// A new request is accepted in the cycle done shows; done is a one-cycle
// strobe. Reset empties the queue at once; entries need no clearing.
module task_deque_with_remove_by_id_unit
#(
    parameter int DEPTH    = tdq_pkg::DEPTH_DEF,
    parameter int ID_WIDTH = tdq_pkg::ID_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [tdq_pkg::KIND_W-1:0]    kind,
    input  logic [tdq_pkg::IDENT_W-1:0]   task_ident,
    output logic                          done,
    output logic [tdq_pkg::IDENT_W-1:0]   removed_ident,
    output logic [tdq_pkg::STATUS_W-1:0]  status,
    output logic [tdq_pkg::OCC_W-1:0]     occupancy
);

    tdq_pkg::dp_cmd_t  cmd;
    tdq_pkg::dp_stat_t stat;

    tdq_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    tdq_datapath
    #(
        .DEPTH    (DEPTH),
        .ID_WIDTH (ID_WIDTH)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .kind          (kind),
        .task_ident    (task_ident),
        .cmd           (cmd),
        .stat          (stat),
        .done          (done),
        .removed_ident (removed_ident),
        .status        (status),
        .occupancy     (occupancy)
    );

    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted request did not raise busy");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while still busy");

    a_full_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == tdq_pkg::ST_FULL |-> occupancy == tdq_pkg::OCC_W'(DEPTH))
        else $error("full status with queue not full");

    a_empty_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == tdq_pkg::ST_EMPTY |-> occupancy == '0)
        else $error("empty status with entries held");

    a_fail_no_ident: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != tdq_pkg::ST_OK |-> removed_ident == '0)
        else $error("identifier returned by failed request");

endmodule

// ===== rtl/tdq_ctrl.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tdq_ctrl
// Sequencer for the task deque: decodes each request and steps the datapath
// through reads, the delete scan and the shift that closes the gap.
// ============================================================================
module tdq_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  tdq_pkg::dp_stat_t  stat,
    output tdq_pkg::dp_cmd_t   cmd,
    output logic               busy
);

    tdq_pkg::ctrl_state_t state_reg;
    tdq_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tdq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.rd_ofs   = tdq_pkg::OFS_ZERO;
        cmd.wr_sel   = tdq_pkg::WR_FRONT;
        cmd.front_op = tdq_pkg::PTR_HOLD;
        cmd.count_op = tdq_pkg::PTR_HOLD;
        cmd.pos_op   = tdq_pkg::POS_HOLD;
        cmd.status   = tdq_pkg::ST_OK;
        unique case (state_reg)
            tdq_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = tdq_pkg::S_EXEC;
                end
            end
            tdq_pkg::S_EXEC:
            begin
                state_next = tdq_pkg::S_IDLE;
                unique case (stat.kind)
                    tdq_pkg::KIND_PUSH_FRONT:
                    begin
                        cmd.finish = 1'b1;
                        if (stat.full)
                        begin
                            cmd.status = tdq_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.wr_en    = 1'b1;
                            cmd.wr_sel   = tdq_pkg::WR_FRONT;
                            cmd.front_op = tdq_pkg::PTR_DEC;
                            cmd.count_op = tdq_pkg::PTR_INC;
                        end
                    end
                    tdq_pkg::KIND_PUSH_BACK:
                    begin
                        cmd.finish = 1'b1;
                        if (stat.full)
                        begin
                            cmd.status = tdq_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.wr_en    = 1'b1;
                            cmd.wr_sel   = tdq_pkg::WR_BACK;
                            cmd.count_op = tdq_pkg::PTR_INC;
                        end
                    end
                    tdq_pkg::KIND_POP_FRONT, tdq_pkg::KIND_POP_BACK:
                    begin
                        if (stat.empty)
                        begin
                            cmd.finish = 1'b1;
                            cmd.status = tdq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_ofs = (stat.kind == tdq_pkg::KIND_POP_FRONT)
                                         ? tdq_pkg::OFS_ZERO : tdq_pkg::OFS_LAST;
                            state_next = tdq_pkg::S_POP_WAIT;
                        end
                    end
                    tdq_pkg::KIND_DELETE:
                    begin
                        if (stat.empty)
                        begin
                            cmd.finish = 1'b1;
                            cmd.status = tdq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_ofs = tdq_pkg::OFS_ZERO;
                            cmd.pos_op = tdq_pkg::POS_CLEAR;
                            state_next = tdq_pkg::S_SCAN;
                        end
                    end
                    default:
                    begin
                        cmd.finish = 1'b1;
                    end
                endcase
            end
            tdq_pkg::S_POP_WAIT:
            begin
                cmd.finish   = 1'b1;
                cmd.got_rd   = 1'b1;
                cmd.count_op = tdq_pkg::PTR_DEC;
                if (stat.kind == tdq_pkg::KIND_POP_FRONT)
                begin
                    cmd.front_op = tdq_pkg::PTR_INC;
                end
                state_next = tdq_pkg::S_IDLE;
            end
            tdq_pkg::S_SCAN:
            begin
                if (stat.match)
                begin
                    if (stat.pos1_lt)
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_ofs = tdq_pkg::OFS_POS1;
                        state_next = tdq_pkg::S_SHIFT;
                    end
                    else
                    begin
                        cmd.finish   = 1'b1;
                        cmd.count_op = tdq_pkg::PTR_DEC;
                        state_next   = tdq_pkg::S_IDLE;
                    end
                end
                else if (stat.pos1_lt)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_ofs = tdq_pkg::OFS_POS1;
                    cmd.pos_op = tdq_pkg::POS_INC;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    cmd.status = tdq_pkg::ST_NOT_FOUND;
                    state_next = tdq_pkg::S_IDLE;
                end
            end
            tdq_pkg::S_SHIFT:
            begin
                // move the entry behind the gap one place toward the front
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = tdq_pkg::WR_SHIFT;
                cmd.pos_op = tdq_pkg::POS_INC;
                if (stat.pos2_lt)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_ofs = tdq_pkg::OFS_POS2;
                end
                else
                begin
                    cmd.finish   = 1'b1;
                    cmd.count_op = tdq_pkg::PTR_DEC;
                    state_next   = tdq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = tdq_pkg::S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != tdq_pkg::S_IDLE);

endmodule

// ===== rtl/tdq_datapath.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tdq_datapath
// Circular entry store with front pointer, count and scan position, the
// address arithmetic around them, and the registered result.
// ============================================================================
module tdq_datapath
#(
    parameter int DEPTH    = tdq_pkg::DEPTH_DEF,
    parameter int ID_WIDTH = tdq_pkg::ID_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [tdq_pkg::KIND_W-1:0]    kind,
    input  logic [tdq_pkg::IDENT_W-1:0]   task_ident,
    input  tdq_pkg::dp_cmd_t              cmd,
    output tdq_pkg::dp_stat_t             stat,
    output logic                          done,
    output logic [tdq_pkg::IDENT_W-1:0]   removed_ident,
    output logic [tdq_pkg::STATUS_W-1:0]  status,
    output logic [tdq_pkg::OCC_W-1:0]     occupancy
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    logic [ID_WIDTH-1:0] mem [DEPTH];

    logic [IW-1:0]                 front_reg;
    logic [IW-1:0]                 front_next;
    logic [CW-1:0]                 count_reg;
    logic [CW-1:0]                 count_next;
    logic [CW-1:0]                 pos_reg;
    logic [CW-1:0]                 pos_next;
    logic [tdq_pkg::KIND_W-1:0]    kind_reg;
    logic [ID_WIDTH-1:0]           ident_reg;
    logic [ID_WIDTH-1:0]           rd_data_reg;
    logic                          done_reg;
    logic [tdq_pkg::IDENT_W-1:0]   removed_reg;
    logic [tdq_pkg::STATUS_W-1:0]  status_reg;
    logic [tdq_pkg::OCC_W-1:0]     occ_reg;

    logic [IW-1:0]       front_dec;
    logic [IW-1:0]       front_inc;
    logic [SW-1:0]       pos1;
    logic [SW-1:0]       pos2;
    logic [SW-1:0]       rd_ofs;
    logic [IW-1:0]       rd_addr;
    logic [IW-1:0]       wr_addr;
    logic [ID_WIDTH-1:0] wr_data;

    function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] base,
                                              input logic [SW-1:0] ofs);
        logic [SW-1:0] sum;
        sum = SW'(base) + ofs;
        if (sum >= SW'(DEPTH))
        begin
            sum = sum - SW'(DEPTH);
        end
        return sum[IW-1:0];
    endfunction

    assign front_dec = (front_reg == '0) ? IW'(DEPTH - 1) : front_reg - 1'b1;
    assign front_inc = (front_reg == IW'(DEPTH - 1)) ? '0 : front_reg + 1'b1;
    assign pos1      = SW'(pos_reg) + SW'(1);
    assign pos2      = SW'(pos_reg) + SW'(2);

    always_comb
    begin
        unique case (cmd.rd_ofs)
            tdq_pkg::OFS_ZERO: rd_ofs = '0;
            tdq_pkg::OFS_LAST: rd_ofs = SW'(count_reg) - SW'(1);
            tdq_pkg::OFS_POS1: rd_ofs = pos1;
            tdq_pkg::OFS_POS2: rd_ofs = pos2;
            default:           rd_ofs = '0;
        endcase
    end

    assign rd_addr = slot_of(front_reg, rd_ofs);

    always_comb
    begin
        unique case (cmd.wr_sel)
            tdq_pkg::WR_FRONT:
            begin
                wr_addr = front_dec;
                wr_data = ident_reg;
            end
            tdq_pkg::WR_BACK:
            begin
                wr_addr = slot_of(front_reg, SW'(count_reg));
                wr_data = ident_reg;
            end
            tdq_pkg::WR_SHIFT:
            begin
                wr_addr = slot_of(front_reg, SW'(pos_reg));
                wr_data = rd_data_reg;
            end
            default:
            begin
                wr_addr = front_dec;
                wr_data = ident_reg;
            end
        endcase
    end

    always_comb
    begin
        unique case (cmd.front_op)
            tdq_pkg::PTR_INC: front_next = front_inc;
            tdq_pkg::PTR_DEC: front_next = front_dec;
            default:          front_next = front_reg;
        endcase
        unique case (cmd.count_op)
            tdq_pkg::PTR_INC: count_next = count_reg + 1'b1;
            tdq_pkg::PTR_DEC: count_next = count_reg - 1'b1;
            default:          count_next = count_reg;
        endcase
        unique case (cmd.pos_op)
            tdq_pkg::POS_CLEAR: pos_next = '0;
            tdq_pkg::POS_INC:   pos_next = pos_reg + 1'b1;
            default:            pos_next = pos_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
            pos_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            front_reg <= front_next;
            count_reg <= count_next;
            pos_reg   <= pos_next;
            done_reg  <= cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= kind;
            ident_reg <= ID_WIDTH'(task_ident);
        end
        if (cmd.finish)
        begin
            removed_reg <= cmd.got_rd ? tdq_pkg::IDENT_W'(rd_data_reg) : '0;
            status_reg  <= cmd.status;
            occ_reg     <= tdq_pkg::OCC_W'(count_next);
        end
    end

    assign stat.kind    = kind_reg;
    assign stat.full    = (count_reg == CW'(DEPTH));
    assign stat.empty   = (count_reg == '0);
    assign stat.match   = (rd_data_reg == ident_reg);
    assign stat.pos1_lt = (pos1 < SW'(count_reg));
    assign stat.pos2_lt = (pos2 < SW'(count_reg));

    assign done          = done_reg;
    assign removed_ident = removed_reg;
    assign status        = status_reg;
    assign occupancy     = occ_reg;

endmodule
